/* design/b64d_pkg.sv */
// Shared types and constants for the base64url stream decoder.
// Used by the front, queue and back modules; depends on nothing else.
`default_nettype none

package b64d_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [5:0] SECOND_UNUSED_MASK = 6'h0F;
    localparam logic [5:0] THIRD_UNUSED_MASK  = 6'h03;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // One classified symbol as it travels from the front to the back.
    typedef struct packed {
        logic [5:0] value;
        logic       invalid;
        logic       last;
    } sym_t;

    // Handshake between a producer and a consumer of sym_t entries.
    typedef struct packed {
        logic valid;
        sym_t entry;
    } sym_flow_t;

endpackage

`default_nettype wire

/* design/b64d_front.sv */
// Front end of the decoder: accepts characters and maps them to 6-bit values.
// Depends on b64d_pkg; feeds b64d_queue.
`default_nettype none

module b64d_front (
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] symbol
    input  wire logic                 s_tlast,   // last
    input  wire logic                 push_ready,
    output b64d_pkg::sym_flow_t       push
);

    logic [7:0] sym_off;
    logic [5:0] value;
    logic       invalid;

    always_comb
    begin
        value   = 6'd0;
        invalid = 1'b0;
        sym_off = 8'd0;
        if (s_tdata >= 8'h41 && s_tdata <= 8'h5A)
        begin
            sym_off = s_tdata - 8'h41;
            value   = sym_off[5:0];
        end
        else if (s_tdata >= 8'h61 && s_tdata <= 8'h7A)
        begin
            sym_off = s_tdata - 8'h61 + 8'd26;
            value   = sym_off[5:0];
        end
        else if (s_tdata >= 8'h30 && s_tdata <= 8'h39)
        begin
            sym_off = s_tdata - 8'h30 + 8'd52;
            value   = sym_off[5:0];
        end
        else if (s_tdata == 8'h2D)
        begin
            value = 6'd62;
        end
        else if (s_tdata == 8'h5F)
        begin
            value = 6'd63;
        end
        else
        begin
            // An invalid character counts as value zero for its group.
            invalid = 1'b1;
        end
    end

    assign s_tready            = push_ready;
    assign push.valid          = s_tvalid;
    assign push.entry.value    = value;
    assign push.entry.invalid  = invalid;
    assign push.entry.last     = s_tlast;

endmodule

`default_nettype wire

/* design/b64d_queue.sv */
// Short queue of classified symbols between the front and the back.
// Depends on b64d_pkg for the entry type and depth.
`default_nettype none

module b64d_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire b64d_pkg::sym_flow_t  push,
    output logic                      push_ready,
    output b64d_pkg::sym_flow_t       pop,
    input  wire logic                 pop_ready
);

    b64d_pkg::sym_t                    mem [b64d_pkg::QUEUE_DEPTH];
    logic [b64d_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [b64d_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [b64d_pkg::QUEUE_CW-1:0]     count_reg, count_next;
    logic                              do_push, do_pop;

    assign push_ready = (count_reg != b64d_pkg::QUEUE_CW'(b64d_pkg::QUEUE_DEPTH));
    assign do_push    = push.valid && push_ready;
    assign pop.valid  = (count_reg != '0);
    assign pop.entry  = mem[rd_ptr_reg];
    assign do_pop     = pop.valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == b64d_pkg::QUEUE_AW'(b64d_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == b64d_pkg::QUEUE_AW'(b64d_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.entry;
    end

endmodule

`default_nettype wire

/* design/b64d_back.sv */
// Back end of the decoder: group tracking, byte assembly, end-of-message check
// and the output register. Depends on b64d_pkg; fed by b64d_queue.
`default_nettype none

module b64d_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire b64d_pkg::sym_flow_t  pop,
    output logic                      pop_ready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // [7:0] data_byte
    output logic [1:0]                m_tuser,   // [0] byte_valid, [1] error
    output logic                      m_tlast    // end_of_message
);

    logic [1:0] pos_reg, pos_next;
    logic [5:0] held_reg, held_next;
    logic       err_seen_reg, err_seen_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic [1:0] m_tuser_reg, m_tuser_next;
    logic       m_tlast_reg, m_tlast_next;

    logic       do_pop;
    logic [5:0] v;
    logic       err_now;
    logic       err;
    logic       produced;
    logic [7:0] byte_val;

    // A queued symbol is taken whenever the output slot is free or draining.
    assign pop_ready = !m_tvalid_reg || m_tready;
    assign do_pop    = pop.valid && pop_ready;

    always_comb
    begin
        v       = pop.entry.invalid ? 6'd0 : pop.entry.value;
        err_now = err_seen_reg || pop.entry.invalid;

        byte_val = 8'd0;
        case (pos_reg)
            b64d_pkg::POS_SECOND: byte_val = {held_reg, v[5:4]};
            b64d_pkg::POS_THIRD:  byte_val = {held_reg[3:0], v[5:2]};
            b64d_pkg::POS_FOURTH: byte_val = {held_reg[1:0], v};
            default:              byte_val = 8'd0;
        endcase

        err = err_now;
        if (pop.entry.last)
        begin
            if (pos_reg == b64d_pkg::POS_FIRST)
                err = 1'b1;
            if (pos_reg == b64d_pkg::POS_SECOND &&
                (v & b64d_pkg::SECOND_UNUSED_MASK) != 6'd0)
                err = 1'b1;
            if (pos_reg == b64d_pkg::POS_THIRD &&
                (v & b64d_pkg::THIRD_UNUSED_MASK) != 6'd0)
                err = 1'b1;
        end
        produced = (pos_reg != b64d_pkg::POS_FIRST) && !err;

        pos_next      = pos_reg;
        held_next     = held_reg;
        err_seen_next = err_seen_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        if (do_pop)
        begin
            if (pop.entry.last)
            begin
                pos_next      = b64d_pkg::POS_FIRST;
                held_next     = 6'd0;
                err_seen_next = 1'b0;
            end
            else
            begin
                pos_next      = pos_reg + 2'd1;
                held_next     = v;
                err_seen_next = err_now;
            end
            if (produced || pop.entry.last)
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = produced ? byte_val : 8'd0;
                m_tuser_next  = {pop.entry.last && err, produced};
                m_tlast_next  = pop.entry.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= b64d_pkg::POS_FIRST;
            held_reg     <= 6'd0;
            err_seen_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            held_reg     <= held_next;
            err_seen_reg <= err_seen_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

/* design/base64url_stream_decoder_unit.sv */
// Unpadded base64url stream decoder: one character per input transaction.
// Path from input transaction to result: the two-entry symbol queue, then the
// output register. Throughput: one character per cycle while the output is not
// stalled, set by the group update in the back end.
// Reset: asynchronous, active low; clears group state, queue and output valid.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
`default_nettype none

module base64url_stream_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] data_byte
    output logic [1:0]       m_tuser,   // [0] byte_valid, [1] error
    output logic             m_tlast    // end_of_message
);

    b64d_pkg::sym_flow_t push;
    b64d_pkg::sym_flow_t pop;
    logic                push_ready;
    logic                pop_ready;

    b64d_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_ready (push_ready),
        .push       (push)
    );

    b64d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (pop),
        .pop_ready  (pop_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

/* test/tb_base64url_stream_decoder_unit.sv */
// Self-checking testbench for the base64url stream decoder unit.
// Drives random and directed character messages with random stalls on both sides,
// predicts every decoded byte and end-of-message status; depends on b64d_pkg.
module tb_base64url_stream_decoder_unit;

    localparam int    CYCLE_LIMIT  = 60000;
    localparam int    RANDOM_CHARS = 500;
    localparam int    DRAIN_CYCLES = 8;
    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
        logic       error;
    } decoded_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] symbol
    logic       s_tlast  = 1'b0;    // last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] data_byte
    logic [1:0] m_tuser;            // [0] byte_valid, [1] error
    logic       m_tlast;            // end_of_message

    char_item_t char_queue[$];
    decoded_t   decoded_due[$];

    // Decoder state as predicted from the accepted characters.
    logic [1:0] grp_pos    = b64d_pkg::POS_FIRST;
    logic [5:0] held_value = 6'd0;
    logic       bad_seen   = 1'b0;

    int   chars_sent  = 0;
    int   mismatches  = 0;
    int   cycle_count = 0;
    logic steady;

    base64url_stream_decoder_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Both sides run without gaps for a stretch in the middle of the stream.
    assign steady = (chars_sent >= 180) && (chars_sent < 300);

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Bit 6 of the result flags a code outside the alphabet.
    function automatic logic [6:0] char_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= "A" && c <= "Z")
            t = c - "A";
        else if (c >= "a" && c <= "z")
            t = c - "a" + 8'd26;
        else if (c >= "0" && c <= "9")
            t = c - "0" + 8'd52;
        else if (c == "-")
            t = 8'd62;
        else if (c == "_")
            t = 8'd63;
        else
            return 7'h40;
        return {1'b0, t[5:0]};
    endfunction

    task automatic decode_char(input logic [7:0] c, input logic is_last);
        logic [6:0] dv;
        logic [5:0] v;
        logic [7:0] b;
        logic       emit;
        logic       bad;
        decoded_t   r;
        dv = char_value(c);
        v  = dv[5:0];
        if (dv[6])
        begin
            bad_seen = 1'b1;
            v = 6'd0;
        end
        emit = 1'b1;
        case (grp_pos)
            b64d_pkg::POS_SECOND: b = {held_value, v[5:4]};
            b64d_pkg::POS_THIRD:  b = {held_value[3:0], v[5:2]};
            b64d_pkg::POS_FOURTH: b = {held_value[1:0], v};
            default:
            begin
                b = 8'd0;
                emit = 1'b0;
            end
        endcase
        bad = bad_seen;
        if (is_last)
        begin
            // A lone trailing symbol or nonzero padding bits spoil the message.
            if (grp_pos == b64d_pkg::POS_FIRST)
                bad = 1'b1;
            if (grp_pos == b64d_pkg::POS_SECOND &&
                (v & b64d_pkg::SECOND_UNUSED_MASK) != 6'd0)
                bad = 1'b1;
            if (grp_pos == b64d_pkg::POS_THIRD &&
                (v & b64d_pkg::THIRD_UNUSED_MASK) != 6'd0)
                bad = 1'b1;
        end
        if (bad)
            emit = 1'b0;
        held_value = v;
        grp_pos    = grp_pos + 2'd1;
        if (is_last)
        begin
            grp_pos    = b64d_pkg::POS_FIRST;
            held_value = 6'd0;
            bad_seen   = 1'b0;
        end
        if (emit || is_last)
        begin
            r.data_byte      = emit ? b : 8'd0;
            r.byte_valid     = emit;
            r.end_of_message = is_last;
            r.error          = is_last && bad;
            decoded_due = {decoded_due, r};
        end
    endtask

    task automatic push_char(input logic [7:0] c, input logic is_last);
        char_item_t it;
        it.symbol = c;
        it.last   = is_last;
        char_queue = {char_queue, it};
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    // Driver: when the slot is free, offers the next pending character unless a random stall holds it back.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                decode_char(s_tdata, s_tlast);
                chars_sent <= chars_sent + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (char_queue.size() > 0 && (steady || $urandom_range(99) >= 23))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= char_queue[0].symbol;
                    s_tlast  <= char_queue[0].last;
                    char_queue.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (decoded_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result data=%02h user=%b last=%b",
                                              m_tdata, m_tuser, m_tlast));
                end
                else
                begin
                    if (m_tdata !== decoded_due[0].data_byte)
                        report_mismatch($sformatf("data_byte %02h, predicted %02h",
                                                  m_tdata, decoded_due[0].data_byte));
                    if (m_tuser[0] !== decoded_due[0].byte_valid)
                        report_mismatch($sformatf("byte_valid %b, predicted %b",
                                                  m_tuser[0], decoded_due[0].byte_valid));
                    if (m_tlast !== decoded_due[0].end_of_message)
                        report_mismatch($sformatf("end_of_message %b, predicted %b",
                                                  m_tlast, decoded_due[0].end_of_message));
                    if (m_tuser[1] !== decoded_due[0].error)
                        report_mismatch($sformatf("error %b, predicted %b",
                                                  m_tuser[1], decoded_due[0].error));
                    decoded_due.pop_front();
                end
            end
            m_tready <= steady || ($urandom_range(99) >= 23);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int         len;
        int         kind;
        int         directed;
        logic [5:0] v;
        logic [7:0] c;

        // Directed messages: extreme values, a lone trailing symbol, nonzero
        // padding bits after two and three symbols, and invalid codes.
        push_text("____");
        push_text("A");
        push_text("AB");
        push_text("AQ");
        push_text("09E");
        push_text("aaB");
        push_char("Z", 1'b0);
        push_char(8'hFF, 1'b0);
        push_char("-", 1'b0);
        push_char(8'h00, 1'b1);
        directed = char_queue.size();

        while (char_queue.size() < directed + RANDOM_CHARS)
        begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            kind = $urandom_range(99);
            if (kind < 75)
            begin
                // Well-formed message with clean padding bits.
                if (len % 4 == 1)
                    len++;
                for (int i = 0; i < len; i++)
                begin
                    v = 6'($urandom_range(63));
                    if (i == len - 1 && len % 4 == 2)
                        v = v & ~b64d_pkg::SECOND_UNUSED_MASK;
                    else if (i == len - 1 && len % 4 == 3)
                        v = v & ~b64d_pkg::THIRD_UNUSED_MASK;
                    push_char(ALPHABET[v], i == len - 1);
                end
            end
            else
            begin
                // Noisy message: arbitrary codes mixed with alphabet characters.
                for (int i = 0; i < len; i++)
                begin
                    c = 8'($urandom);
                    if ($urandom_range(3) != 0)
                        c = ALPHABET[$urandom_range(63)];
                    push_char(c, i == len - 1);
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (char_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (decoded_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64url_stream_decoder_unit.sv
test/tb_base64url_stream_decoder_unit.sv
